### src/rtuchk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtuchk_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 256;
   localparam int unsigned MIN_FRAME_BYTES = 4;
   localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] ADDR_BROADCAST = 8'd0;
   localparam logic [7:0] ADDR_CONFIG    = 8'd254;
   localparam logic [7:0] OWN_ADDR_RESET = 8'd1;

   typedef logic [7:0]       byte_type;
   typedef logic [15:0]      crc_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      CLASS_OWN       = 2'd0,
      CLASS_BROADCAST = 2'd1,
      CLASS_CONFIG    = 2'd2,
      CLASS_OTHER     = 2'd3
   } addr_class_type;

   typedef enum logic [1:0] {
      REASON_OK    = 2'd0,
      REASON_CRC   = 2'd1,
      REASON_ADDR  = 2'd2,
      REASON_SHORT = 2'd3
   } reason_type;

   typedef struct packed {
      byte_type data_byte;
      logic     last_byte;
   } beat_type;

   typedef struct packed {
      logic           accepted;
      byte_type       function_code;
      addr_class_type address_class;
      reason_type     reason;
   } result_type;

   // crc-16/modbus over one byte, reflected, lsb first
   function automatic crc_type crc_byte(input crc_type crc_in, input byte_type b);
      crc_type c;
      c = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### src/rtuchk_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtuchk_req_if;
   import rtuchk_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### src/rtuchk_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtuchk_rsp_if;
   import rtuchk_pkg::*;

   logic           valid;
   logic           ready;
   logic           accepted;
   byte_type       function_code;
   addr_class_type address_class;
   reason_type     reason;

   modport source (output valid, output accepted, output function_code,
                   output address_class, output reason, input ready);
   modport sink   (input valid, input accepted, input function_code,
                   input address_class, input reason, output ready);
endinterface

`default_nettype wire

### src/rtuchk_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rtuchk_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   rtuchk_req_if.sink              req_bus,
   output      logic               stage_valid,
   output      rtuchk_pkg::beat_type stage_beat,
   input  wire logic               stage_take
);
   import rtuchk_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;
   logic     req_fire;

   // stage frees up in the same cycle its beat moves on
   assign req_bus.ready = !valid_ff || stage_take;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         beat_ff.data_byte <= req_bus.data_byte;
         beat_ff.last_byte <= req_bus.last_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_beat  = beat_ff;

endmodule

`default_nettype wire

### src/rtuchk_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rtuchk_frame_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 stage_valid,
   input  wire rtuchk_pkg::beat_type stage_beat,
   output      logic                 stage_take,
   input  wire rtuchk_pkg::byte_type own_address,
   rtuchk_rsp_if.source              rsp_bus
);
   import rtuchk_pkg::*;

   crc_type    crc_now_ff, crc_now_in;
   crc_type    crc_back_ff, crc_back_in;
   byte_type   prev_byte_ff, prev_byte_in;
   byte_type   unit_addr_ff, unit_addr_in;
   byte_type   func_ff, func_in;
   count_type  cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic           out_free;
   logic           frame_end;
   count_type      count_next;
   byte_type       unit_addr_cur;
   byte_type       func_cur;
   crc_type        trailer;
   addr_class_type cls;
   reason_type     why;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign stage_take = stage_valid && (!stage_beat.last_byte || out_free);
   assign frame_end  = stage_take && stage_beat.last_byte;

   assign count_next = (cnt_ff < count_type'(MAX_FRAME_BYTES)) ?
                       cnt_ff + count_type'(1) : count_type'(MAX_FRAME_BYTES);

   assign unit_addr_cur = (cnt_ff == count_type'(0)) ? stage_beat.data_byte : unit_addr_ff;
   assign func_cur      = (cnt_ff == count_type'(1)) ? stage_beat.data_byte : func_ff;

   // trailer arrives low byte first
   assign trailer = {stage_beat.data_byte, prev_byte_ff};

   always_comb begin
      if (unit_addr_cur == own_address) begin
         cls = CLASS_OWN;
      end else if (unit_addr_cur == ADDR_BROADCAST) begin
         cls = CLASS_BROADCAST;
      end else if (unit_addr_cur == ADDR_CONFIG) begin
         cls = CLASS_CONFIG;
      end else begin
         cls = CLASS_OTHER;
      end
   end

   // crc_back_ff holds the crc before the previous byte, i.e. over all but the trailer
   always_comb begin
      if (crc_back_ff != trailer) begin
         why = REASON_CRC;
      end else if (cls == CLASS_OTHER) begin
         why = REASON_ADDR;
      end else begin
         why = REASON_OK;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (frame_end) begin
         if (count_next < count_type'(MIN_FRAME_BYTES)) begin
            rsp_in.accepted      = 1'b0;
            rsp_in.function_code = '0;
            rsp_in.address_class = CLASS_OTHER;
            rsp_in.reason        = REASON_SHORT;
         end else begin
            rsp_in.accepted      = (why == REASON_OK);
            rsp_in.function_code = func_cur;
            rsp_in.address_class = cls;
            rsp_in.reason        = why;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      crc_now_in   = crc_now_ff;
      crc_back_in  = crc_back_ff;
      prev_byte_in = prev_byte_ff;
      unit_addr_in = unit_addr_ff;
      func_in      = func_ff;
      cnt_in       = cnt_ff;
      if (frame_end) begin
         crc_now_in   = CRC_INIT;
         crc_back_in  = CRC_INIT;
         prev_byte_in = '0;
         unit_addr_in = '0;
         func_in      = '0;
         cnt_in       = '0;
      end else if (stage_take) begin
         crc_now_in   = crc_byte(crc_now_ff, stage_beat.data_byte);
         crc_back_in  = crc_now_ff;
         prev_byte_in = stage_beat.data_byte;
         unit_addr_in = unit_addr_cur;
         func_in      = func_cur;
         cnt_in       = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_now_ff   <= CRC_INIT;
         crc_back_ff  <= CRC_INIT;
         prev_byte_ff <= '0;
         unit_addr_ff <= '0;
         func_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_now_ff   <= crc_now_in;
         crc_back_ff  <= crc_back_in;
         prev_byte_ff <= prev_byte_in;
         unit_addr_ff <= unit_addr_in;
         func_ff      <= func_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.accepted      = rsp_ff.accepted;
   assign rsp_bus.function_code = rsp_ff.function_code;
   assign rsp_bus.address_class = rsp_ff.address_class;
   assign rsp_bus.reason        = rsp_ff.reason;

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> rsp_valid_ff)
      else $error("final beat did not load a result");

   a_end_clears_frame: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (cnt_ff == count_type'(0)) && (crc_now_ff == CRC_INIT))
      else $error("frame state not cleared after final beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !frame_end)
      else $error("pending result overwritten");

   a_accept_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.accepted == (rsp_ff.reason == REASON_OK)))
      else $error("accept flag disagrees with reason");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= count_type'(MAX_FRAME_BYTES))
      else $error("byte count beyond maximum");

endmodule

`default_nettype wire

### src/rtu_frame_crc_address_check.sv
`timescale 1ns / 1ps
`default_nettype none

// result: the final byte's beat passes the input register, then loads the result register
// throughput: one byte per cycle, save while a final byte stalls; the byte-wide crc step sits between the
//   input register and the frame state/result register
// stalls: a final byte waits in the input register while the previous result is unaccepted
// reset: synchronous, active high; clears frame state, crc to 0xffff and
//   own address to 1

module rtu_frame_crc_address_check (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rtuchk_req_if.sink                req_bus,
   rtuchk_rsp_if.source              rsp_bus,
   input  wire logic                 csr_write_enable,
   input  wire rtuchk_pkg::byte_type csr_write_data
);
   import rtuchk_pkg::*;

   byte_type own_addr_ff, own_addr_in;
   logic     stage_valid;
   beat_type stage_beat;
   logic     stage_take;

   assign own_addr_in = csr_write_enable ? csr_write_data : own_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= OWN_ADDR_RESET;
      end else begin
         own_addr_ff <= own_addr_in;
      end
   end

   rtuchk_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .stage_valid (stage_valid),
      .stage_beat  (stage_beat),
      .stage_take  (stage_take)
   );

   rtuchk_frame_core u_frame_core (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_beat  (stage_beat),
      .stage_take  (stage_take),
      .own_address (own_addr_ff),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire
